[design/nlsu_pkg.sv]
`timescale 1ns / 1ps

package nlsu_pkg;

	localparam int CH_W            = 8;
	localparam int KIND_W          = 3;
	localparam int ERR_W           = 4;
	localparam int VAL_W           = 64;
	localparam int LEN_W           = 16;
	localparam int TAIL_W          = 2;
	localparam int TDATA_W         = 88;
	localparam int VALUE_BITS_DEF  = 64;
	localparam int LENGTH_BITS_DEF = 16;
	localparam int FIFO_DEPTH      = 4;

	localparam int ERR_LSB  = 0;
	localparam int VAL_LSB  = ERR_LSB + ERR_W;
	localparam int LEN_LSB  = VAL_LSB + VAL_W;
	localparam int TAIL_LSB = LEN_LSB + LEN_W;
	localparam int PAD_LSB  = TAIL_LSB + TAIL_W;

	localparam logic [CH_W-1:0] CHR_0     = 8'h30;
	localparam logic [CH_W-1:0] CHR_1     = 8'h31;
	localparam logic [CH_W-1:0] CHR_9     = 8'h39;
	localparam logic [CH_W-1:0] CHR_A     = 8'h61;
	localparam logic [CH_W-1:0] CHR_F     = 8'h66;
	localparam logic [CH_W-1:0] CHR_Z     = 8'h7a;
	localparam logic [CH_W-1:0] CHR_X     = 8'h78;
	localparam logic [CH_W-1:0] CHR_B     = 8'h62;
	localparam logic [CH_W-1:0] CHR_E     = 8'h65;
	localparam logic [CH_W-1:0] CHR_DOT   = 8'h2e;
	localparam logic [CH_W-1:0] CHR_PLUS  = 8'h2b;
	localparam logic [CH_W-1:0] CHR_MINUS = 8'h2d;
	localparam logic [CH_W-1:0] CHR_UNDER = 8'h5f;
	localparam logic [CH_W-1:0] CASE_BIT  = 8'h20;
	localparam logic [CH_W-1:0] BYTE_MAX  = 8'hff;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_DOT_FIRST = 4'd1,
		PH_ZERO      = 4'd2,
		PH_DEC       = 4'd3,
		PH_HEX_START = 4'd4,
		PH_HEX       = 4'd5,
		PH_BIN_START = 4'd6,
		PH_BIN       = 4'd7,
		PH_FRAC      = 4'd8,
		PH_DOT2      = 4'd9,
		PH_EXP_START = 4'd10,
		PH_EXP_SIGN  = 4'd11,
		PH_EXP       = 4'd12
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_INT   = 3'd0,
		KIND_FLOAT = 3'd1,
		KIND_BYTE  = 3'd2,
		KIND_NAN   = 3'd3,
		KIND_ERR   = 3'd4
	} kind_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE     = 4'd0,
		ERR_EXPONENT = 4'd1,
		ERR_DOUBLE   = 4'd2,
		ERR_IDENT    = 4'd3,
		ERR_HEX_DIG  = 4'd4,
		ERR_HEX_DOT  = 4'd5,
		ERR_BIN_DIG  = 4'd6,
		ERR_BIN_DOT  = 4'd7,
		ERR_OVERFLOW = 4'd8
	} err_t;

	typedef struct packed {
		logic       is_end;
		logic       is_dig;
		logic       is_idt;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_bin;
		logic       is_zero;
		logic       is_dot;
		logic       is_x;
		logic       is_b;
		logic       is_e;
		logic       is_sign;
	} cls_t;

endpackage

[design/nlsu_front.sv]
`timescale 1ns / 1ps

module nlsu_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [nlsu_pkg::CH_W-1:0]    in_ch,
	input  logic                         in_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output nlsu_pkg::cls_t               out_cls
);

	logic                      valid_s1;
	nlsu_pkg::cls_t            cls_s1;
	nlsu_pkg::cls_t            cls;
	logic [nlsu_pkg::CH_W-1:0] lc;
	logic                      alpha;
	logic                      hexlet;

	always_comb begin
		lc          = in_ch | nlsu_pkg::CASE_BIT;
		alpha       = !in_end && lc >= nlsu_pkg::CHR_A && lc <= nlsu_pkg::CHR_Z;
		hexlet      = !in_end && lc >= nlsu_pkg::CHR_A && lc <= nlsu_pkg::CHR_F;
		cls.is_end  = in_end;
		cls.is_dig  = !in_end && in_ch >= nlsu_pkg::CHR_0 && in_ch <= nlsu_pkg::CHR_9;
		cls.is_idt  = alpha || (!in_end && in_ch == nlsu_pkg::CHR_UNDER);
		cls.is_hex  = cls.is_dig || hexlet;
		cls.hex_val = hexlet ? 4'(in_ch[3:0] + 4'd9) : in_ch[3:0];
		cls.is_bin  = !in_end && (in_ch == nlsu_pkg::CHR_0 || in_ch == nlsu_pkg::CHR_1);
		cls.is_zero = !in_end && in_ch == nlsu_pkg::CHR_0;
		cls.is_dot  = !in_end && in_ch == nlsu_pkg::CHR_DOT;
		cls.is_x    = !in_end && lc == nlsu_pkg::CHR_X;
		cls.is_b    = !in_end && lc == nlsu_pkg::CHR_B;
		cls.is_e    = !in_end && lc == nlsu_pkg::CHR_E;
		cls.is_sign = !in_end && (in_ch == nlsu_pkg::CHR_PLUS || in_ch == nlsu_pkg::CHR_MINUS);
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_cls   = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cls_s1 <= cls;
		end
	end

endmodule

[design/nlsu_fifo.sv]
`timescale 1ns / 1ps

module nlsu_fifo #(
	parameter int DEPTH = nlsu_pkg::FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  nlsu_pkg::cls_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output nlsu_pkg::cls_t rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	nlsu_pkg::cls_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;

	assign wr_ready = count_q != CW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[design/nlsu_back.sv]
`timescale 1ns / 1ps

module nlsu_back #(
	parameter int VALUE_BITS  = nlsu_pkg::VALUE_BITS_DEF,
	parameter int LENGTH_BITS = nlsu_pkg::LENGTH_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  nlsu_pkg::cls_t                   in_cls,
	output logic                             out_valid,
	input  logic                             out_ready,
	output nlsu_pkg::kind_t                  out_kind,
	output nlsu_pkg::err_t                   out_err,
	output logic signed [nlsu_pkg::VAL_W-1:0] out_value,
	output logic [nlsu_pkg::LEN_W-1:0]       out_len,
	output logic [nlsu_pkg::TAIL_W-1:0]      out_tail
);

	localparam int ACC_W = VALUE_BITS + 4;
	localparam int LX_W  = (LENGTH_BITS > nlsu_pkg::LEN_W) ? LENGTH_BITS : nlsu_pkg::LEN_W;

	nlsu_pkg::phase_t          phase_q, phase_n;
	logic                      dot_q, dot_n;
	logic [VALUE_BITS-1:0]     acc_q, acc_n;
	logic                      ovf_q, ovf_n;
	logic [LENGTH_BITS-1:0]    cnt_q, cnt_n;

	logic                      out_valid_q;
	nlsu_pkg::kind_t           kind_q;
	nlsu_pkg::err_t            err_q;
	logic signed [nlsu_pkg::VAL_W-1:0] value_q;
	logic [nlsu_pkg::LEN_W-1:0]  len_q;
	logic [nlsu_pkg::TAIL_W-1:0] tail_q;

	logic                      pop;
	logic                      emit;
	nlsu_pkg::kind_t           e_kind;
	nlsu_pkg::err_t            e_err;
	logic [VALUE_BITS-1:0]     e_val;
	logic [nlsu_pkg::TAIL_W-1:0] e_tail;
	logic [LENGTH_BITS-1:0]    e_cnt;
	logic [nlsu_pkg::TAIL_W-1:0] t;
	logic [LENGTH_BITS-1:0]    cnt_inc;
	logic [ACC_W-1:0]          acc10;
	logic                      dec_ovf;
	logic [VALUE_BITS-1:0]     byte_val;
	logic signed [nlsu_pkg::VAL_W-1:0] val_ext;
	logic [LX_W-1:0]           len_ext;

	assign in_ready  = !emit || !out_valid_q || out_ready;
	assign pop       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_err   = err_q;
	assign out_value = value_q;
	assign out_len   = len_q;
	assign out_tail  = tail_q;

	always_comb begin
		t        = in_cls.is_end ? 2'd0 : 2'd1;
		cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
		acc10    = (ACC_W'(acc_q) << 3) + (ACC_W'(acc_q) << 1) + ACC_W'(in_cls.hex_val);
		dec_ovf  = |acc10[ACC_W-1:VALUE_BITS-1];
		byte_val = (acc_q > VALUE_BITS'(nlsu_pkg::BYTE_MAX)) ?
			VALUE_BITS'(nlsu_pkg::BYTE_MAX) : acc_q;

		phase_n = phase_q;
		dot_n   = dot_q;
		acc_n   = acc_q;
		ovf_n   = ovf_q;
		cnt_n   = cnt_q;
		emit    = 1'b0;
		e_kind  = nlsu_pkg::KIND_INT;
		e_err   = nlsu_pkg::ERR_NONE;
		e_val   = '0;
		e_tail  = t;
		e_cnt   = cnt_q;

		unique case (phase_q)
			nlsu_pkg::PH_DOT_FIRST: begin
				if (in_cls.is_dig) begin
					phase_n = nlsu_pkg::PH_FRAC;
					dot_n   = 1'b1;
					cnt_n   = cnt_inc;
				end else begin
					emit   = 1'b1;
					e_kind = nlsu_pkg::KIND_NAN;
					e_tail = 2'd1 + t;
				end
			end
			nlsu_pkg::PH_ZERO, nlsu_pkg::PH_DEC: begin
				if (phase_q == nlsu_pkg::PH_ZERO && in_cls.is_x) begin
					phase_n = nlsu_pkg::PH_HEX_START;
					cnt_n   = cnt_inc;
				end else if (phase_q == nlsu_pkg::PH_ZERO && in_cls.is_b) begin
					phase_n = nlsu_pkg::PH_BIN_START;
					cnt_n   = cnt_inc;
				end else begin
					phase_n = nlsu_pkg::PH_DEC;
					if (in_cls.is_dig) begin
						if (!ovf_q) begin
							if (dec_ovf) begin
								ovf_n = 1'b1;
							end else begin
								acc_n = acc10[VALUE_BITS-1:0];
							end
						end
						cnt_n = cnt_inc;
					end else if (in_cls.is_dot) begin
						phase_n = nlsu_pkg::PH_FRAC;
						dot_n   = 1'b1;
						cnt_n   = cnt_inc;
					end else if (in_cls.is_e) begin
						phase_n = nlsu_pkg::PH_EXP_START;
						dot_n   = 1'b0;
						cnt_n   = cnt_inc;
					end else if (in_cls.is_b) begin
						emit = 1'b1;
						if (ovf_q) begin
							e_kind = nlsu_pkg::KIND_ERR;
							e_err  = nlsu_pkg::ERR_OVERFLOW;
							e_tail = 2'd1;
						end else begin
							e_kind = nlsu_pkg::KIND_BYTE;
							e_val  = byte_val;
							e_cnt  = cnt_inc;
							e_tail = 2'd0;
						end
					end else if (in_cls.is_idt) begin
						emit   = 1'b1;
						e_kind = nlsu_pkg::KIND_ERR;
						e_err  = nlsu_pkg::ERR_IDENT;
						e_tail = 2'd1;
					end else if (ovf_q) begin
						emit   = 1'b1;
						e_kind = nlsu_pkg::KIND_ERR;
						e_err  = nlsu_pkg::ERR_OVERFLOW;
					end else begin
						emit  = 1'b1;
						e_val = acc_q;
					end
				end
			end
			nlsu_pkg::PH_HEX_START, nlsu_pkg::PH_HEX: begin
				if (in_cls.is_hex) begin
					acc_n   = {acc_q[VALUE_BITS-5:0], in_cls.hex_val};
					phase_n = nlsu_pkg::PH_HEX;
					cnt_n   = cnt_inc;
				end else begin
					emit = 1'b1;
					if (phase_q == nlsu_pkg::PH_HEX_START) begin
						e_kind = nlsu_pkg::KIND_ERR;
						e_err  = nlsu_pkg::ERR_HEX_DIG;
					end else if (in_cls.is_dot) begin
						e_kind = nlsu_pkg::KIND_ERR;
						e_err  = nlsu_pkg::ERR_HEX_DOT;
						e_tail = 2'd1;
					end else if (in_cls.is_idt) begin
						e_kind = nlsu_pkg::KIND_ERR;
						e_err  = nlsu_pkg::ERR_IDENT;
						e_tail = 2'd1;
					end else begin
						e_val = acc_q;
					end
				end
			end
			nlsu_pkg::PH_BIN_START, nlsu_pkg::PH_BIN: begin
				if (in_cls.is_bin) begin
					acc_n   = {acc_q[VALUE_BITS-2:0], in_cls.hex_val[0]};
					phase_n = nlsu_pkg::PH_BIN;
					cnt_n   = cnt_inc;
				end else begin
					emit = 1'b1;
					if (phase_q == nlsu_pkg::PH_BIN_START) begin
						e_kind = nlsu_pkg::KIND_ERR;
						e_err  = nlsu_pkg::ERR_BIN_DIG;
					end else if (in_cls.is_dot) begin
						e_kind = nlsu_pkg::KIND_ERR;
						e_err  = nlsu_pkg::ERR_BIN_DOT;
						e_tail = 2'd1;
					end else if (in_cls.is_idt) begin
						e_kind = nlsu_pkg::KIND_ERR;
						e_err  = nlsu_pkg::ERR_IDENT;
						e_tail = 2'd1;
					end else begin
						e_val = acc_q;
					end
				end
			end
			nlsu_pkg::PH_FRAC, nlsu_pkg::PH_EXP: begin
				if (in_cls.is_dig) begin
					cnt_n = cnt_inc;
				end else if (phase_q == nlsu_pkg::PH_FRAC && in_cls.is_e) begin
					phase_n = nlsu_pkg::PH_EXP_START;
					cnt_n   = cnt_inc;
				end else if (in_cls.is_dot && dot_q) begin
					phase_n = nlsu_pkg::PH_DOT2;
				end else if (in_cls.is_idt) begin
					emit   = 1'b1;
					e_kind = nlsu_pkg::KIND_ERR;
					e_err  = nlsu_pkg::ERR_IDENT;
					e_tail = 2'd1;
				end else begin
					emit   = 1'b1;
					e_kind = nlsu_pkg::KIND_FLOAT;
				end
			end
			nlsu_pkg::PH_DOT2: begin
				emit = 1'b1;
				if (in_cls.is_dig) begin
					e_kind = nlsu_pkg::KIND_ERR;
					e_err  = nlsu_pkg::ERR_DOUBLE;
					e_tail = 2'd2;
				end else begin
					e_kind = nlsu_pkg::KIND_FLOAT;
					e_tail = 2'd1 + t;
				end
			end
			nlsu_pkg::PH_EXP_START, nlsu_pkg::PH_EXP_SIGN: begin
				if (phase_q == nlsu_pkg::PH_EXP_START && in_cls.is_sign) begin
					phase_n = nlsu_pkg::PH_EXP_SIGN;
					cnt_n   = cnt_inc;
				end else if (in_cls.is_dig) begin
					phase_n = nlsu_pkg::PH_EXP;
					cnt_n   = cnt_inc;
				end else begin
					emit   = 1'b1;
					e_kind = nlsu_pkg::KIND_ERR;
					e_err  = nlsu_pkg::ERR_EXPONENT;
				end
			end
			default: begin
				phase_n = nlsu_pkg::PH_IDLE;
				dot_n   = 1'b0;
				acc_n   = '0;
				ovf_n   = 1'b0;
				cnt_n   = '0;
				if (in_cls.is_end) begin
					phase_n = nlsu_pkg::PH_IDLE;
				end else if (in_cls.is_dot) begin
					phase_n = nlsu_pkg::PH_DOT_FIRST;
					cnt_n   = LENGTH_BITS'(1);
				end else if (in_cls.is_zero) begin
					phase_n = nlsu_pkg::PH_ZERO;
					cnt_n   = LENGTH_BITS'(1);
				end else if (in_cls.is_dig) begin
					phase_n = nlsu_pkg::PH_DEC;
					acc_n   = VALUE_BITS'(in_cls.hex_val);
					cnt_n   = LENGTH_BITS'(1);
				end else begin
					emit   = 1'b1;
					e_kind = nlsu_pkg::KIND_NAN;
					e_tail = 2'd1;
				end
			end
		endcase

		if (emit) begin
			phase_n = nlsu_pkg::PH_IDLE;
			dot_n   = 1'b0;
			acc_n   = '0;
			ovf_n   = 1'b0;
			cnt_n   = '0;
		end

		val_ext = nlsu_pkg::VAL_W'(signed'(e_val));
		if (e_kind != nlsu_pkg::KIND_INT && e_kind != nlsu_pkg::KIND_BYTE) begin
			val_ext = '0;
		end
		len_ext = LX_W'(e_cnt);
		if (e_kind == nlsu_pkg::KIND_NAN) begin
			len_ext = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= nlsu_pkg::PH_IDLE;
			dot_q       <= 1'b0;
			acc_q       <= '0;
			ovf_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_n;
				dot_q   <= dot_n;
				acc_q   <= acc_n;
				ovf_q   <= ovf_n;
				cnt_q   <= cnt_n;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			kind_q  <= e_kind;
			err_q   <= e_err;
			value_q <= val_ext;
			len_q   <= len_ext[nlsu_pkg::LEN_W-1:0];
			tail_q  <= e_tail;
		end
	end

endmodule

[design/number_literal_scanner_unit.sv]
`timescale 1ns / 1ps

// Number literal scanner: one character word per cycle on the s_ side, one result word per
// finished token on the m_ side. Each accepted character passes a classify register, a
// four-entry queue and the scanner, so the sustained rate is one character per clock while
// s_tready is high; a result word is presented from an output register once the character
// ending the token has passed the classify register and the queue, and waits there while the
// next token keeps scanning. An output stall holds the scanner only at the next character that
// ends a token; the queue then fills and s_tready drops. tail_returned tells how many of the
// last characters sent belong to the next token and must be sent again.
module number_literal_scanner_unit #(
	parameter int VALUE_BITS  = nlsu_pkg::VALUE_BITS_DEF,
	parameter int LENGTH_BITS = nlsu_pkg::LENGTH_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [nlsu_pkg::CH_W-1:0]      s_tdata,  // [7:0] ch
	input  logic                           s_tuser,  // [0] end_of_text
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [nlsu_pkg::TDATA_W-1:0]   m_tdata,  // [3:0] error_code, [67:4] value,
	                                                 // [83:68] token_length,
	                                                 // [85:84] tail_returned, [87:86] zero
	output logic [nlsu_pkg::KIND_W-1:0]    m_tuser   // [2:0] kind
);

	logic                                 fr_valid;
	logic                                 fr_ready;
	nlsu_pkg::cls_t                       fr_cls;
	logic                                 q_valid;
	logic                                 q_ready;
	nlsu_pkg::cls_t                       q_cls;
	nlsu_pkg::kind_t                      kind;
	nlsu_pkg::err_t                       err;
	logic signed [nlsu_pkg::VAL_W-1:0]    value;
	logic [nlsu_pkg::LEN_W-1:0]           len;
	logic [nlsu_pkg::TAIL_W-1:0]          tail;

	nlsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_ch     (s_tdata),
		.in_end    (s_tuser),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_cls   (fr_cls)
	);

	nlsu_fifo #(
		.DEPTH (nlsu_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_data  (fr_cls),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_cls)
	);

	nlsu_back #(
		.VALUE_BITS  (VALUE_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_cls    (q_cls),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (kind),
		.out_err   (err),
		.out_value (value),
		.out_len   (len),
		.out_tail  (tail)
	);

	assign m_tuser = kind;
	assign m_tdata = {2'b00, tail, len, value, err};

	a_nan_len : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind == nlsu_pkg::KIND_NAN |-> len == '0)
		else $error("not-a-number result with nonzero length");

	a_val_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind != nlsu_pkg::KIND_INT && kind != nlsu_pkg::KIND_BYTE |-> value == '0)
		else $error("value nonzero for float, error or not-a-number");

	a_err_kind : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (kind == nlsu_pkg::KIND_ERR) == (err != nlsu_pkg::ERR_NONE))
		else $error("error code disagrees with kind");

	a_tail : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> tail != 2'd3)
		else $error("tail count out of range");

endmodule
